>>> hw/rtl/b32ae_pkg.sv
// Shared constants and helper functions for the bech32 address encoder.
`timescale 1ns / 1ps
`default_nettype none

package b32ae_pkg;

  localparam int KEY_HASH_BYTES_DEF = 28;

  localparam int CSUM_W  = 30;
  localparam int GROUP_W = 5;
  localparam int ACC_W   = 12;
  localparam int CNT_W   = 4;
  localparam int CHAR_W  = 7;
  localparam int NID_W   = 4;
  localparam int STEP_W  = 4;

  // Register indexes on the configuration port
  localparam logic REG_NET_ID = 1'b0;

  localparam logic [NID_W-1:0] NET_MAIN = 4'd1;

  localparam logic [CHAR_W-1:0] CHAR_SEP = 7'h31;  // '1'

  localparam logic [3:0] HRP_LEN_MAIN = 4'd4;
  localparam logic [3:0] HRP_LEN_TEST = 4'd9;

  localparam logic [255:0] ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
  localparam logic [31:0]  HRP_MAIN = "addr";
  localparam logic [71:0]  HRP_TEST = {"addr_", "test"};

  localparam logic [CSUM_W-1:0] GEN [5] = '{
    30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
  };

  // One polymod step: shift in a group, fold the five top bits back in
  function automatic logic [CSUM_W-1:0] poly_step(input logic [CSUM_W-1:0] c,
                                                 input logic [GROUP_W-1:0] v);
    logic [4:0]        top;
    logic [CSUM_W-1:0] r;
    top = c[CSUM_W-1 -: 5];
    r   = {c[CSUM_W-6:0], v};
    for (int j = 0; j < 5; j++) begin
      if (top[j]) begin
        r = r ^ GEN[j];
      end
    end
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] alpha_char(input logic [GROUP_W-1:0] g);
    logic [4:0] r;
    logic [7:0] ch;
    r  = ~g;
    ch = ALPHABET[{r, 3'b000} +: 8];
    return ch[CHAR_W-1:0];
  endfunction

  function automatic logic [CHAR_W-1:0] hrp_char(input logic is_main,
                                                input logic [3:0] idx);
    logic [3:0] off;
    logic [7:0] ch;
    if (is_main) begin
      off = 4'd3 - idx;
      ch  = HRP_MAIN[{off[1:0], 3'b000} +: 8];
    end else begin
      off = 4'd8 - idx;
      ch  = HRP_TEST[{off, 3'b000} +: 8];
    end
    return ch[CHAR_W-1:0];
  endfunction

  // Checksum state after the prefix expansion, worked out at elaboration
  function automatic logic [CSUM_W-1:0] hrp_seed(input logic is_main);
    logic [CSUM_W-1:0] c;
    logic [3:0]        len;
    logic [CHAR_W-1:0] ch;
    c   = 30'd1;
    len = is_main ? HRP_LEN_MAIN : HRP_LEN_TEST;
    for (int i = 0; i < 9; i++) begin
      if (4'(i) < len) begin
        ch = hrp_char(is_main, 4'(i));
        c  = poly_step(c, {3'b000, ch[6:5]});
      end
    end
    c = poly_step(c, 5'd0);
    for (int i = 0; i < 9; i++) begin
      if (4'(i) < len) begin
        ch = hrp_char(is_main, 4'(i));
        c  = poly_step(c, ch[4:0]);
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bech32_address_encoder_core.sv
// Bech32 address encoder: hash bytes in, address text characters out.
`timescale 1ns / 1ps
`default_nettype none

// Takes the 2*KEY_HASH_BYTES hash bytes of one address, one byte per beat, and
// returns the ASCII text of the address one character per beat. The first byte
// of an address sends the prefix ("addr" when the network nibble is 1, else the
// longer test-network prefix), the separator and the type-byte groups ahead of
// its own groups; the last byte adds a padded group when bits are left over,
// idle checksum folding and six checksum characters, the last one flagged. A
// sequencer moves one 5-bit group a cycle, unless the output stalls, through
// the regrouping register and the checksum register. A new byte is accepted
// only in the idle state, once every group of the last byte is out. The
// network nibble is taken at the first byte of each address.
module bech32_address_encoder_core
  import b32ae_pkg::*;
#(
  parameter int KEY_HASH_BYTES = KEY_HASH_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,

  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic [7:0]        in_hash_byte,

  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic [CHAR_W-1:0] out_char,
  output      logic              out_is_last,

  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output      logic [31:0]       prdata,
  output      logic              pready
);

  localparam int TOTAL_BYTES = 2 * KEY_HASH_BYTES;
  localparam int IDX_W       = $clog2(TOTAL_BYTES + 1);

  localparam logic [CSUM_W-1:0] SEED_MAIN = hrp_seed(1'b1);
  localparam logic [CSUM_W-1:0] SEED_TEST = hrp_seed(1'b0);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PREFIX = 6'b000010,
    S_GROUPS = 6'b000100,
    S_PAD    = 6'b001000,
    S_FEED   = 6'b010000,
    S_CSUM   = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic [NID_W-1:0]   net_id_r, net_id_nxt;
  logic [NID_W-1:0]   nid_r, nid_nxt;
  logic [CSUM_W-1:0]  check_r, check_nxt;
  logic [ACC_W-1:0]   bit_acc_r, bit_acc_nxt;
  logic [CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [IDX_W-1:0]   byte_idx_r, byte_idx_nxt;
  logic [7:0]         byte_r, byte_nxt;
  logic               pending_r, pending_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  logic               cfg_wr;
  logic               in_acc;
  logic               slot_free;
  logic               is_main;
  logic               is_final;
  logic [CNT_W-1:0]   shamt;
  logic [ACC_W-1:0]   grp_full;
  logic [GROUP_W-1:0] grp;
  logic [ACC_W-1:0]   rem_mask;
  logic [ACC_W-1:0]   pad_full;
  logic [2:0]         pad_shift;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = (paddr[2] == REG_NET_ID) ? {28'd0, net_id_r} : 32'd0;

  assign in_ready    = (state_r == S_IDLE);
  assign in_acc      = in_valid && in_ready;
  assign out_valid   = out_valid_r;
  assign out_char    = out_char_r;
  assign out_is_last = out_last_r;

  assign slot_free = !out_valid_r || out_ready;
  assign is_main   = (nid_r == NET_MAIN);
  assign is_final  = (byte_idx_r == IDX_W'(TOTAL_BYTES));

  // Top group of the accumulator, the bits that stay behind it and the padded last group
  assign shamt     = bit_cnt_r - CNT_W'(GROUP_W);
  assign grp_full  = bit_acc_r >> shamt;
  assign grp       = grp_full[GROUP_W-1:0];
  assign rem_mask  = (ACC_W'(1) << shamt) - ACC_W'(1);
  assign pad_shift = 3'd5 - bit_cnt_r[2:0];
  assign pad_full  = bit_acc_r << pad_shift;

  always_comb begin
    state_nxt      = state_r;
    net_id_nxt     = net_id_r;
    nid_nxt        = nid_r;
    check_nxt      = check_r;
    bit_acc_nxt    = bit_acc_r;
    bit_cnt_nxt    = bit_cnt_r;
    byte_idx_nxt   = byte_idx_r;
    byte_nxt       = byte_r;
    pending_nxt    = pending_r;
    step_nxt       = step_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;

    if (cfg_wr && paddr[2] == REG_NET_ID) begin
      net_id_nxt = pwdata[NID_W-1:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          byte_nxt     = in_hash_byte;
          byte_idx_nxt = byte_idx_r + IDX_W'(1);
          if (byte_idx_r == '0) begin
            nid_nxt     = net_id_r;
            check_nxt   = (net_id_r == NET_MAIN) ? SEED_MAIN : SEED_TEST;
            bit_acc_nxt = '0;
            bit_cnt_nxt = '0;
            pending_nxt = 1'b1;
            step_nxt    = '0;
            state_nxt   = S_PREFIX;
          end else begin
            bit_acc_nxt = {bit_acc_r[3:0], in_hash_byte};
            bit_cnt_nxt = bit_cnt_r + CNT_W'(8);
            pending_nxt = 1'b0;
            state_nxt   = S_GROUPS;
          end
        end
      end

      S_PREFIX: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b0;
          if (step_r < (is_main ? HRP_LEN_MAIN : HRP_LEN_TEST)) begin
            out_char_nxt = hrp_char(is_main, step_r);
            step_nxt     = step_r + STEP_W'(1);
          end else begin
            // separator, then load the type byte into the regrouping register
            out_char_nxt = CHAR_SEP;
            bit_acc_nxt  = {8'd0, nid_r};
            bit_cnt_nxt  = CNT_W'(8);
            state_nxt    = S_GROUPS;
          end
        end
      end

      S_GROUPS: begin
        if (bit_cnt_r >= CNT_W'(GROUP_W)) begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_last_nxt  = 1'b0;
            out_char_nxt  = alpha_char(grp);
            check_nxt     = poly_step(check_r, grp);
            bit_acc_nxt   = bit_acc_r & rem_mask;
            bit_cnt_nxt   = shamt;
            if (shamt < CNT_W'(GROUP_W) && !pending_r) begin
              if (is_final) begin
                step_nxt  = '0;
                state_nxt = (shamt != '0) ? S_PAD : S_FEED;
              end else begin
                state_nxt = S_IDLE;
              end
            end
          end
        end else if (pending_r) begin
          // the held hash byte follows the type byte
          bit_acc_nxt = {bit_acc_r[3:0], byte_r};
          bit_cnt_nxt = bit_cnt_r + CNT_W'(8);
          pending_nxt = 1'b0;
        end else if (is_final) begin
          step_nxt  = '0;
          state_nxt = (bit_cnt_r != '0) ? S_PAD : S_FEED;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_PAD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b0;
          out_char_nxt  = alpha_char(pad_full[GROUP_W-1:0]);
          check_nxt     = poly_step(check_r, pad_full[GROUP_W-1:0]);
          bit_acc_nxt   = '0;
          bit_cnt_nxt   = '0;
          step_nxt      = '0;
          state_nxt     = S_FEED;
        end
      end

      S_FEED: begin
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(5)) begin
          check_nxt = poly_step(check_r, '0) ^ CSUM_W'(1);
          step_nxt  = '0;
          state_nxt = S_CSUM;
        end else begin
          check_nxt = poly_step(check_r, '0);
        end
      end

      S_CSUM: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = alpha_char(check_r[CSUM_W-1 -: GROUP_W]);
          out_last_nxt  = (step_r == STEP_W'(5));
          check_nxt     = check_r << GROUP_W;
          step_nxt      = step_r + STEP_W'(1);
          if (step_r == STEP_W'(5)) begin
            // address done: back to reset values
            check_nxt    = CSUM_W'(1);
            bit_acc_nxt  = '0;
            bit_cnt_nxt  = '0;
            byte_idx_nxt = '0;
            step_nxt     = '0;
            state_nxt    = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      net_id_r     <= NET_MAIN;
      check_r      <= CSUM_W'(1);
      bit_acc_r    <= '0;
      bit_cnt_r    <= '0;
      byte_idx_r   <= '0;
      pending_r    <= 1'b0;
      step_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      net_id_r     <= net_id_nxt;
      check_r      <= check_nxt;
      bit_acc_r    <= bit_acc_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      byte_idx_r   <= byte_idx_nxt;
      pending_r    <= pending_nxt;
      step_r       <= step_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nid_r      <= nid_nxt;
    byte_r     <= byte_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r <= CNT_W'(ACC_W))
    else $error("regrouping count out of range");

  a_first_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && byte_idx_r == '0 |=> state_r == S_PREFIX)
    else $error("first byte did not start the prefix");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_last |-> (state_r == S_IDLE || state_r == S_PREFIX)
                                 && bit_cnt_r == '0)
    else $error("last character held while address still in progress");

  a_csum_clean: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CSUM || state_r == S_FEED |-> bit_cnt_r == '0 && !pending_r)
    else $error("checksum phase with bits left in the accumulator");
`endif

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the bech32 address encoder core.
`timescale 1ns / 1ps

module tb;
  import b32ae_pkg::*;

  localparam int ADDR_BYTES = 2 * KEY_HASH_BYTES_DEF;
  localparam int RAND_BYTES = 17;
  localparam int LIMIT_NS   = 6_000_000;

  localparam logic [2:0] NET_REG_ADDR = {2'b00, REG_NET_ID} << 2;
  localparam logic [2:0] NO_REG_ADDR  = 3'd4;

  localparam string B32_CHARS = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
  localparam logic [CSUM_W-1:0] POLY [5] = '{
    30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
  };

  typedef enum logic [1:0] {ROW_BYTE, ROW_RUN, ROW_CFG} row_kind_t;
  typedef struct packed {
    row_kind_t  kind;
    logic [2:0] addr;
    logic [7:0] value;
    logic [7:0] count;
  } dir_row_t;

  localparam int DIR_N = 13;
  // Three addresses: mainnet from reset, a mid-address switch to testnet,
  // an ignored write off the register map, then the top network nibble.
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{ROW_BYTE, 3'd0,         8'h00, 8'd0},
    '{ROW_BYTE, 3'd0,         8'hff, 8'd0},
    '{ROW_BYTE, 3'd0,         8'h80, 8'd0},
    '{ROW_BYTE, 3'd0,         8'h01, 8'd0},
    '{ROW_CFG,  NET_REG_ADDR, 8'h00, 8'd0},
    '{ROW_RUN,  3'd0,         8'h00, 8'd51},
    '{ROW_BYTE, 3'd0,         8'h7f, 8'd0},
    '{ROW_BYTE, 3'd0,         8'hff, 8'd0},
    '{ROW_CFG,  NO_REG_ADDR,  8'h01, 8'd0},
    '{ROW_CFG,  NET_REG_ADDR, 8'h0f, 8'd0},
    '{ROW_RUN,  3'd0,         8'h00, 8'd54},
    '{ROW_BYTE, 3'd0,         8'h00, 8'd0},
    '{ROW_BYTE, 3'd0,         8'h00, 8'd0}
  };
  string dir_text [DIR_N] = '{
    "addr1qyq", "", "", "", "", "", "", {"addr", "_test1qrl"}, "", "", "", "",
    {"addr", "_test1puq"}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_hash_byte = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CHAR_W-1:0] out_char;
  logic              out_is_last;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = 3'd0;
  logic [31:0]       pwdata = 32'd0;
  logic [31:0]       prdata;
  logic              pready;

  string             byte_text = "";
  logic              quiet = 1'b0;
  int                stall_left = 0;
  int                bytes_sent = 0;

  // Encoder state as the predictor sees it
  logic [NID_W-1:0]  net_cfg = NET_MAIN;
  logic [CSUM_W-1:0] cs_reg = 30'd1;
  logic [ACC_W-1:0]  acc = '0;
  logic [CNT_W-1:0]  acc_bits = '0;
  int                addr_pos = 0;

  logic [CHAR_W-1:0] step_char [$];
  logic              step_last [$];
  logic [CHAR_W-1:0] text_due [$];
  logic              last_due [$];

  int mismatches = 0;
  int chars_seen = 0;
  int addrs_done = 0;
  int addrs_main = 0;
  int addrs_test = 0;

  bech32_address_encoder_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_hash_byte (in_hash_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .out_is_last  (out_is_last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #4 clk = ~clk;

  initial begin
    #(LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void fold_group(input logic [GROUP_W-1:0] g);
    logic [4:0] top;
    top    = cs_reg[CSUM_W-1 -: 5];
    cs_reg = {cs_reg[CSUM_W-6:0], g};
    for (int j = 0; j < 5; j++) begin
      if (top[j]) begin
        cs_reg = cs_reg ^ POLY[j];
      end
    end
  endfunction

  function automatic void emit_char(input logic [CHAR_W-1:0] ch, input logic last);
    step_char.push_back(ch);
    step_last.push_back(last);
  endfunction

  function automatic void emit_group(input logic [GROUP_W-1:0] g);
    fold_group(g);
    emit_char(CHAR_W'(B32_CHARS[g]), 1'b0);
  endfunction

  function automatic void shift_in_byte(input logic [7:0] b);
    acc      = {acc[3:0], b};
    acc_bits = acc_bits + 4'd8;
    while (acc_bits >= 4'd5) begin
      acc_bits = acc_bits - 4'd5;
      emit_group(GROUP_W'(acc >> acc_bits));
    end
    acc = acc & ((12'd1 << acc_bits) - 12'd1);
  endfunction

  // Characters caused by one hash byte, left in step_char / step_last
  function automatic void encode_byte(input logic [7:0] b);
    string             pfx;
    logic [7:0]        pc;
    logic [CSUM_W-1:0] sum;
    step_char.delete();
    step_last.delete();
    if (addr_pos == 0) begin
      pfx = "addr";
      if (net_cfg != NET_MAIN) pfx = {pfx, "_test"};
      cs_reg   = 30'd1;
      acc      = '0;
      acc_bits = '0;
      for (int i = 0; i < pfx.len(); i++) begin
        pc = pfx[i];
        fold_group(GROUP_W'(pc >> 5));
      end
      fold_group(5'd0);
      for (int i = 0; i < pfx.len(); i++) begin
        pc = pfx[i];
        fold_group(pc[4:0]);
      end
      for (int i = 0; i < pfx.len(); i++) emit_char(CHAR_W'(pfx[i]), 1'b0);
      emit_char(CHAR_SEP, 1'b0);
      shift_in_byte({4'h0, net_cfg});
      if (net_cfg == NET_MAIN) addrs_main++;
      else addrs_test++;
    end
    shift_in_byte(b);
    addr_pos++;
    if (addr_pos >= ADDR_BYTES) begin
      if (acc_bits != 0) emit_group(GROUP_W'(acc << (5 - acc_bits)));
      repeat (6) fold_group(5'd0);
      sum = cs_reg ^ 30'd1;
      for (int i = 0; i < 6; i++) begin
        emit_char(CHAR_W'(B32_CHARS[sum[5*(5-i) +: 5]]), i == 5);
      end
      cs_reg   = 30'd1;
      acc      = '0;
      acc_bits = '0;
      addr_pos = 0;
    end
  endfunction

  // ---------------------------------------------------------------- monitor

  task automatic flag_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what,
               want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    logic [CHAR_W-1:0] want_c;
    logic              want_l;
    if (rst_n) begin
      if (psel && penable && pwrite && pready &&
          (paddr >> 2) == 3'(REG_NET_ID)) begin
        net_cfg = pwdata[NID_W-1:0];
      end
      if (in_valid && in_ready) begin
        encode_byte(in_hash_byte);
        if (byte_text.len() != 0) begin
          // spelled-out text for rows that start an address
          for (int i = 0; i < byte_text.len(); i++) begin
            text_due.push_back(CHAR_W'(byte_text[i]));
            last_due.push_back(1'b0);
          end
        end else begin
          foreach (step_char[i]) begin
            text_due.push_back(step_char[i]);
            last_due.push_back(step_last[i]);
          end
        end
      end
      if (out_valid && out_ready) begin
        chars_seen++;
        if (text_due.size() == 0) begin
          flag_mismatch("character with nothing pending", 0, out_char);
        end else begin
          want_c = text_due.pop_front();
          want_l = last_due.pop_front();
          if (out_char !== want_c) flag_mismatch("out_char", want_c, out_char);
          if (out_is_last !== want_l) flag_mismatch("out_is_last", want_l, out_is_last);
          if (want_l) addrs_done++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 90) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = 1'b1;
      if (!quiet && $urandom_range(0, 99) < 20) stall_left = pick_len();
    end
  end

  // Enter right after an accepting edge or at an idle point; leave at the
  // edge that takes the beat, with valid still high.
  task automatic send_byte(input logic [7:0] b, input string text);
    int gap;
    gap = (quiet || $urandom_range(0, 99) < 45) ? 0 : pick_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_hash_byte = b;
    byte_text    = text;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    while (text_due.size() != 0) @(negedge clk);
  endtask

  // Write a register once the encoder is idle, then read the network id back
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    logic [31:0] rd;
    @(negedge clk);
    in_valid = 1'b0;
    wait_drained();
    repeat (16) @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = value;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    pwrite  = 1'b0;
    paddr   = NET_REG_ADDR;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (rd !== 32'(net_cfg)) flag_mismatch("network id read-back", net_cfg, rd);
  endtask

  function automatic logic [3:0] pick_net();
    case ($urandom_range(0, 3))
      0:       return NET_MAIN;
      1:       return 4'd0;
      2:       return 4'hf;
      default: return 4'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'h00;
    if (r < 16) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < DIR_N; r++) begin
      case (DIR_ROWS[r].kind)
        ROW_BYTE: send_byte(DIR_ROWS[r].value, dir_text[r]);
        ROW_RUN:  repeat (DIR_ROWS[r].count) send_byte(pick_byte(), "");
        ROW_CFG:  write_reg(DIR_ROWS[r].addr, 32'(DIR_ROWS[r].value));
        default:  ;
      endcase
    end

    for (int n = 0; n < RAND_BYTES; n++) begin
      if ($urandom_range(0, 99) < 5) quiet = ~quiet;
      if ((bytes_sent % ADDR_BYTES == 0 && $urandom_range(0, 2) == 0) ||
          $urandom_range(0, 99) < 3) begin
        if ($urandom_range(0, 7) == 0) begin
          write_reg(NO_REG_ADDR | 3'($urandom_range(0, 3)), $urandom);
        end else begin
          write_reg(NET_REG_ADDR, {$urandom_range(0, 1) ? 28'h0 : 28'($urandom),
                                   pick_net()});
        end
      end
      send_byte(pick_byte(), "");
    end

    @(negedge clk);
    in_valid = 1'b0;
    wait_drained();
    repeat (40) @(negedge clk);
    if (text_due.size() != 0) flag_mismatch("characters never seen", text_due.size(), 0);

    $display("Sent %0d hash bytes over %0d mainnet and %0d testnet addresses,",
             bytes_sent, addrs_main, addrs_test);
    $display("checked %0d characters including %0d checksums; %0d mismatches.",
             chars_seen, addrs_done, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> bech32_address_encoder_core.f
hw/rtl/b32ae_pkg.sv
hw/rtl/bech32_address_encoder_core.sv
dv/tb.sv
